/* hdl/sks_pkg.sv */
// Shared types and constants for the streaming k-smallest selector.
package sks_pkg;

    localparam int KMaxDefault     = 16;
    localparam int ValueWidthDef   = 32;
    localparam int KeepCountW      = 5;
    localparam logic [KeepCountW-1:0] KeepCountRst = 5'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_EMPTY
    } t_state;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctrl;

endpackage

/* hdl/streaming_k_smallest_select.sv */
// Top level of the streaming k-smallest selector: cell chain, control and output register.
//
//  channel   | dir | handshake                  | word contents
//  s_axis    | in  | tvalid/tready              | tdata: sample_value; tlast: end_of_stream
//  m_axis    | out | tvalid/tready              | tdata: kept_value; tlast: run_end;
//            |     |                            | tuser: no_answer
//  cfg       | in  | valid/ready                | data: keep_count
//
// While a stream is collected one word is taken every cycle unless cfg valid is high;
// each word is sorted into the chain in the cycle it is accepted, all cells in parallel.
// After the last word, the chain shifts toward the output until k results are loaded
// (one a cycle unless m_axis stalls, largest first); s_axis and cfg wait till then.
// A short stream gives one flagged result, loaded from ST_EMPTY once the output register is free.
// Back-pressure on m_axis stalls the report; the output register holds its word.
// Reset (i_rst_n low, synchronous) empties the chain and sets keep_count to 4.
module streaming_k_smallest_select
    import sks_pkg::*;
#(
    parameter int K_MAX       = KMaxDefault,
    parameter int VALUE_WIDTH = ValueWidthDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,  // [VW-1:0] sample_value
    input  logic                           i_s_axis_tlast,    // end_of_stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [((VALUE_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,  // [VW-1:0] kept_value
    output logic                           o_m_axis_tlast,    // run_end
    output logic                           o_m_axis_tuser,    // [0] no_answer
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [KeepCountW-1:0]          i_cfg_data         // keep_count
);

    localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(K_MAX + 1);
    localparam int IDX_W   = (K_MAX > 1) ? $clog2(K_MAX) : 1;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_fill, n_fill;
    logic [CNT_W-1:0]       r_left, n_left;
    logic [KeepCountW-1:0]  r_kc, n_kc;
    logic                   r_ovalid, n_ovalid;
    logic signed [VALUE_WIDTH-1:0] r_odata, n_odata;
    logic                   r_olast, n_olast;
    logic                   r_oempty, n_oempty;

    logic signed [VALUE_WIDTH-1:0] w_sample;
    logic signed [VALUE_WIDTH-1:0] w_val  [K_MAX];
    logic signed [VALUE_WIDTH-1:0] w_prev [K_MAX];
    logic [K_MAX-1:0]       w_keep;
    logic [K_MAX-1:0]       w_prev_keep;
    logic [K_MAX-1:0]       w_occ;
    logic [CNT_W-1:0]       w_k;
    logic [CNT_W-1:0]       w_fill_ins;
    logic signed [VALUE_WIDTH-1:0] w_tail;
    logic                   w_s_acc;
    logic                   w_cfg_acc;
    logic                   w_out_free;
    t_cell_ctrl             w_ctrl;

    assign w_sample   = i_s_axis_tdata[VALUE_WIDTH-1:0];
    assign o_cfg_ready     = (r_state == ST_IDLE);
    assign o_s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign w_s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_ovalid || i_m_axis_tready;

    // clamp k into 1..K_MAX
    always_comb begin
        if (r_kc == '0) begin
            w_k = CNT_W'(1);
        end else if (int'(r_kc) > K_MAX) begin
            w_k = CNT_W'(K_MAX);
        end else begin
            w_k = CNT_W'(int'(r_kc));
        end
    end

    assign w_fill_ins = (r_fill < w_k) ? r_fill + CNT_W'(1) : r_fill;
    assign w_tail     = w_val[IDX_W'(w_k - CNT_W'(1))];

    assign w_ctrl.insert = w_s_acc;
    assign w_ctrl.drain  = (r_state == ST_DRAIN) && w_out_free;

    for (genvar g = 0; g < K_MAX; g++) begin : g_cell
        assign w_occ[g] = (CNT_W'(g) < r_fill);
        if (g == 0) begin : g_head
            assign w_prev[g]      = w_sample;
            assign w_prev_keep[g] = 1'b1;
        end else begin : g_body
            assign w_prev[g]      = w_val[g-1];
            assign w_prev_keep[g] = w_keep[g-1];
        end
        sks_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occupied   (w_occ[g]),
            .i_sample     (w_sample),
            .i_prev_value (w_prev[g]),
            .i_prev_keep  (w_prev_keep[g]),
            .o_value      (w_val[g]),
            .o_keep       (w_keep[g])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_left   = r_left;
        n_kc     = r_kc;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_odata  = r_odata;
        n_olast  = r_olast;
        n_oempty = r_oempty;
        case (r_state)
            ST_IDLE: begin
                if (w_cfg_acc) begin
                    n_kc   = i_cfg_data;
                    n_fill = '0;
                end else if (w_s_acc) begin
                    if (i_s_axis_tlast) begin
                        n_fill = '0;
                        n_left = w_k;
                        n_state = (w_fill_ins < w_k) ? ST_EMPTY : ST_DRAIN;
                    end else begin
                        n_fill = w_fill_ins;
                    end
                end
            end
            ST_DRAIN: begin
                // emit the top cell and advance the chain toward it
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = w_tail;
                    n_olast  = (r_left == CNT_W'(1));
                    n_oempty = 1'b0;
                    n_left   = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EMPTY: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = '0;
                    n_olast  = 1'b1;
                    n_oempty = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_left   <= '0;
            r_kc     <= KeepCountRst;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_left   <= n_left;
            r_kc     <= n_kc;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odata  <= n_odata;
        r_olast  <= n_olast;
        r_oempty <= n_oempty;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = TDATA_W'($unsigned(r_odata));
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_oempty;

endmodule

/* hdl/sks_cell.sv */
// One cell of the sorted insertion chain: holds one kept value.
module sks_cell
    import sks_pkg::*;
#(
    parameter int VALUE_WIDTH = ValueWidthDef
) (
    input  logic                          i_clk,
    input  t_cell_ctrl                    i_ctrl,
    input  logic                          i_occupied,
    input  logic signed [VALUE_WIDTH-1:0] i_sample,
    input  logic signed [VALUE_WIDTH-1:0] i_prev_value,
    input  logic                          i_prev_keep,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic                          o_keep
);

    logic signed [VALUE_WIDTH-1:0] r_value;
    logic signed [VALUE_WIDTH-1:0] n_value;

    // an empty cell acts as +infinity; equal values stay put
    assign o_keep  = i_occupied && (r_value <= i_sample);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.drain) begin
            n_value = i_prev_value;
        end else if (i_ctrl.insert && !o_keep) begin
            n_value = i_prev_keep ? i_sample : i_prev_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

/* hdl/sks_checker.sv */
// Port-level checks for the streaming k-smallest selector, bound to the top level.
module sks_checker
    import sks_pkg::*;
#(
    parameter int TDATA_W = 32
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_axis_tvalid,
    input logic               o_s_axis_tready,
    input logic               i_s_axis_tlast,
    input logic               o_m_axis_tvalid,
    input logic               i_m_axis_tready,
    input logic [TDATA_W-1:0] o_m_axis_tdata,
    input logic               o_m_axis_tlast,
    input logic               o_m_axis_tuser,
    input logic               o_cfg_ready
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("result word changed while stalled");

    // the empty flag only comes as a one-word run of zero
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast && (o_m_axis_tdata == '0))
        else $error("empty result not a lone zero word");

    // a last word starts the report, so input is held off next cycle
    a_report_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> !o_s_axis_tready)
        else $error("input taken during report");

    // input is never ready while configuration is blocked
    a_ready_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> o_cfg_ready)
        else $error("input ready outside idle");

endmodule

bind streaming_k_smallest_select sks_checker #(
    .TDATA_W (((VALUE_WIDTH + 7) / 8) * 8)
) u_sks_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_cfg_ready     (o_cfg_ready)
);

/* verif/tb.sv */
// Self-checking testbench for the streaming k-smallest selector: tracker class and top module.
package sks_tb_pkg;
    import sks_pkg::*;

    localparam int TbKMax = KMaxDefault;
    localparam int TbVw   = ValueWidthDef;

    typedef struct packed {
        logic [TbVw-1:0] value;
        logic            run_end;
        logic            no_answer;
    } t_kept_word;

    // Tracks the k smallest values of the current stream and the report words still owed.
    class k_smallest_tracker;
        logic [TbVw-1:0]       ascending [TbKMax];
        int unsigned           held;
        logic [KeepCountW-1:0] keep_count;
        t_kept_word            kept_words_due [$];
        int                    mismatches;
        int                    words_checked;
        int                    reports_done;
        int                    short_reports;

        function new();
            keep_count    = KeepCountRst;
            held          = 0;
            mismatches    = 0;
            words_checked = 0;
            reports_done  = 0;
            short_reports = 0;
            foreach (ascending[i]) ascending[i] = '0;
        endfunction

        function int unsigned active_k();
            if (keep_count == 0) return 1;
            if (keep_count > TbKMax) return TbKMax;
            return keep_count;
        endfunction

        // A write also empties the chain.
        function void write_keep_count(logic [KeepCountW-1:0] k);
            keep_count = k;
            held       = 0;
        endfunction

        function void insert_value(logic [TbVw-1:0] v, int unsigned n);
            int unsigned pos;
            pos = n;
            while (pos > 0 && $signed(ascending[pos-1]) > $signed(v)) begin
                ascending[pos] = ascending[pos-1];
                pos--;
            end
            ascending[pos] = v;
        endfunction

        function void note_sample(logic [TbVw-1:0] v, logic last);
            int unsigned k;
            t_kept_word  w;
            k = active_k();
            if (held > k) held = k;
            if (held < k) begin
                insert_value(v, held);
                held++;
            end else if ($signed(v) < $signed(ascending[k-1])) begin
                insert_value(v, k - 1);
            end
            if (!last) return;
            if (held < k) begin
                w.value     = '0;
                w.run_end   = 1'b1;
                w.no_answer = 1'b1;
                kept_words_due.push_back(w);
            end else begin
                // Report largest first.
                for (int unsigned i = held; i > 0; i--) begin
                    w.value     = ascending[i-1];
                    w.run_end   = (i == 1);
                    w.no_answer = 1'b0;
                    kept_words_due.push_back(w);
                end
            end
            held = 0;
        endfunction

        function void flag_mismatch(string what, t_kept_word due, t_kept_word got);
            mismatches++;
            if (mismatches <= 10)
                $display({"[%0t] %s: expected value=%0d run_end=%0b no_answer=%0b,",
                          " got value=%0d run_end=%0b no_answer=%0b"},
                         $time, what, $signed(due.value), due.run_end, due.no_answer,
                         $signed(got.value), got.run_end, got.no_answer);
        endfunction

        function void check_kept_word(logic [TbVw-1:0] value, logic run_end, logic no_answer);
            t_kept_word got;
            t_kept_word due;
            got.value     = value;
            got.run_end   = run_end;
            got.no_answer = no_answer;
            if (kept_words_due.size() == 0) begin
                due = '0;
                flag_mismatch("word with nothing owed", due, got);
                return;
            end
            due = kept_words_due.pop_front();
            words_checked++;
            if (due.run_end) reports_done++;
            if (due.no_answer) short_reports++;
            if (due.value !== got.value || due.run_end !== got.run_end ||
                due.no_answer !== got.no_answer)
                flag_mismatch("report word mismatch", due, got);
        endfunction
    endclass

endpackage

module tb;
    import sks_pkg::*;
    import sks_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW          = TbVw;
    localparam int DW          = ((VW + 7) / 8) * 8;
    localparam int TARGET_SAMPLES = 410;
    localparam int SETTLE_CYCLES  = TbKMax + 6;
    localparam int CYCLE_LIMIT    = 300000;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_CHOKE,
        RX_PERIODIC
    } t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [DW-1:0]         i_s_axis_tdata;
    logic                  i_s_axis_tlast;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [DW-1:0]         o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic                  o_m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [KeepCountW-1:0] i_cfg_data;

    k_smallest_tracker tracker;
    int       cycle_count = 0;
    int       burst_left  = 0;
    int       samples_sent = 0;
    int       cfg_writes  = 0;
    t_rx_mode rx_mode     = RX_OPEN;
    int       rx_left     = 0;

    streaming_k_smallest_select u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver back-pressure: switch at random between stall styles.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 40);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            RX_OPEN:     i_m_axis_tready <= 1'b1;
            RX_COIN:     i_m_axis_tready <= $urandom_range(0, 1);
            RX_CHOKE:    i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: i_m_axis_tready <= (cycle_count[1:0] != 2'b00);
            default:     i_m_axis_tready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_kept_word(o_m_axis_tdata[VW-1:0], o_m_axis_tlast, o_m_axis_tuser);
    end

    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return {1'b0, {(VW-1){1'b1}}};
                    1:       return {1'b1, {(VW-1){1'b0}}};
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2:    return VW'(int'($urandom_range(0, 16)) - 8);
            default: return VW'($urandom());
        endcase
    endfunction

    function automatic logic [KeepCountW-1:0] pick_keep_count();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return KeepCountW'(TbKMax);
            3:       return KeepCountW'(1);
            4:       return KeepCountW'(TbKMax + 1);
            default: return KeepCountW'($urandom_range(0, (1 << KeepCountW) - 1));
        endcase
    endfunction

    // Send one word; open a new burst after a random gap when the last one ran out.
    task automatic send_sample(input logic [VW-1:0] v, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= DW'(v);
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.note_sample(v, last);
        samples_sent++;
        burst_left--;
    endtask

    // Drop valid and wait out every owed word plus the drain latency.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.kept_words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_keep_count(input logic [KeepCountW-1:0] k);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= k;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_keep_count(k);
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned eff;
        int          n_streams;
        int          len;
        bit          broken;
        logic [KeepCountW-1:0] k_set;

        tracker         = new();
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        i_m_axis_tready <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset k of four: extremes, with a replacement on the last word.
        send_sample({1'b0, {(VW-1){1'b1}}}, 1'b0);
        send_sample({1'b1, {(VW-1){1'b0}}}, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(VW'(1), 1'b1);
        // Equal values never displace the largest kept one.
        repeat (4) send_sample(VW'(5), 1'b0);
        send_sample(VW'(5), 1'b1);
        // Short streams report one flagged word.
        send_sample(VW'(7), 1'b0);
        send_sample(VW'(-3), 1'b1);
        send_sample(VW'(42), 1'b1);

        write_keep_count(KeepCountW'(1));
        send_sample({(VW/2){2'b10}}, 1'b0);
        send_sample({(VW/2){2'b01}}, 1'b0);
        send_sample({1'b1, {(VW-2){1'b0}}, 1'b1}, 1'b1);

        // Abandon a stream mid-way: the write clears it, zero k acts as one.
        write_keep_count(KeepCountW'(TbKMax));
        send_sample(VW'(-100), 1'b0);
        send_sample(VW'(-200), 1'b0);
        write_keep_count('0);
        send_sample(VW'(9), 1'b1);

        // Oversized k clamps to the chain length.
        write_keep_count('1);
        for (int i = 0; i < TbKMax + 3; i++)
            send_sample(pick_value(), i == TbKMax + 2);

        while (samples_sent < TARGET_SAMPLES) begin
            k_set = pick_keep_count();
            write_keep_count(k_set);
            eff = (k_set == 0) ? 1 : (k_set > TbKMax) ? TbKMax : k_set;
            n_streams = $urandom_range(1, 4);
            broken = 1'b0;
            for (int s = 0; s < n_streams && !broken; s++) begin
                case ($urandom_range(0, 9))
                    0: len = (eff > 1) ? $urandom_range(1, eff - 1) : 1;
                    1: begin
                        len    = $urandom_range(1, eff + 2);
                        broken = 1'b1;
                    end
                    default: len = eff + $urandom_range(0, eff + 4);
                endcase
                for (int i = 0; i < len; i++)
                    send_sample(pick_value(), (i == len - 1) && !broken);
            end
        end

        wait_idle();
        $display("Sent %0d samples over %0d keep_count writes; checked %0d words",
                 samples_sent, cfg_writes, tracker.words_checked);
        $display("Reports: %0d total, %0d for short streams", tracker.reports_done,
                 tracker.short_reports);
        if (tracker.mismatches == 0 && tracker.kept_words_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("Mismatches: %0d, words still owed: %0d", tracker.mismatches,
                     tracker.kept_words_due.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
